@@ sv/hfb_pkg.sv @@
package hfb_pkg;

    localparam int MAX_REFS  = 64;
    localparam int MAX_SITES = 1024;
    localparam int FRAC_BITS = 10;
    localparam int LUT_SIZE  = 32;

    localparam int REF_W     = $clog2(MAX_REFS);
    localparam int SITE_W    = $clog2(MAX_SITES);
    localparam int CNT_W     = SITE_W + 1;
    localparam int NREF_W    = 7;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int FWD_AW    = SITE_W + REF_W;
    localparam int BWD_AW    = REF_W + 1;
    localparam int ROW_W     = MAX_REFS + 1;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t NEG_INF = 32'sh8000_0000;
    localparam val_t POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W:0] S33_MIN = -33'sd2147483648;
    localparam logic signed [VAL_W:0] S33_MAX = 33'sd2147483647;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REFS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_EMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_EMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAY         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH       = 3'd4;

    // ln(1+exp(-k/4)) in q16
    localparam logic [15:0] LSE_LUT [LUT_SIZE] = '{
        16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
        16'd8318,  16'd6567,  16'd5170,  16'd4061,  16'd3184,  16'd2493,  16'd1950,  16'd1523,
        16'd1189,  16'd928,   16'd724,   16'd565,   16'd440,   16'd343,   16'd267,   16'd208,
        16'd162,   16'd126,   16'd98,    16'd77,    16'd60,    16'd47,    16'd36,    16'd28
    };

    typedef enum logic [4:0] {
        S_IDLE, S_RESP,
        S_F0_RD, S_F0_LAT, S_F0_WR,
        S_FS_RD, S_FS_LAT, S_FI_INIT, S_FI_RD, S_FI_ADD, S_FI_LSE, S_FI_WR,
        S_B_INIT,
        S_N_INIT, S_N1_RD, S_N1_ADD, S_N1_LSE, S_N2_RD, S_N2_ADD, S_N2_WR,
        S_BS_RD, S_BS_LAT, S_BI_INIT, S_BI_RD, S_BI_ADD, S_BI_LSE, S_BI_WR
    } state_t;

    typedef enum logic [1:0] {FW_EMIT, FW_ACC_EMIT, FW_NORM} fwd_wsel_t;
    typedef enum logic {BW_ZERO, BW_ACC} bwd_wsel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_LSE} acc_op_t;
    typedef enum logic [1:0] {TERM_HOLD, TERM_FWD_TR, TERM_FWD_BWD, TERM_BWD_TR_EMIT} term_op_t;

    typedef struct packed {
        logic              site_we;
        logic [SITE_W-1:0] site_waddr;
        logic [SITE_W-1:0] site_raddr;
        logic              latch_site;
        logic              fwd_we;
        logic [FWD_AW-1:0] fwd_waddr;
        fwd_wsel_t         fwd_wsel;
        logic [FWD_AW-1:0] fwd_raddr;
        logic              fwd_raddr_req;
        logic              bwd_we;
        logic [BWD_AW-1:0] bwd_waddr;
        bwd_wsel_t         bwd_wsel;
        logic [BWD_AW-1:0] bwd_raddr;
        acc_op_t           acc_op;
        term_op_t          term_op;
        logic [REF_W-1:0]  emit_idx;
        logic              tr_same;
        logic              req_capture;
        logic              out_load;
        logic              results_ready;
        logic [CNT_W-1:0]  site_count;
    } cmd_t;

    function automatic val_t sat33(input logic signed [VAL_W:0] s);
        if (s <= S33_MIN)
            return NEG_INF;
        if (s > S33_MAX)
            return POS_MAX;
        return s[VAL_W-1:0];
    endfunction

    function automatic val_t sat_add(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (a == NEG_INF || b == NEG_INF)
            return NEG_INF;
        return sat33(s);
    endfunction

    function automatic val_t sat_sub(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (a == NEG_INF || b == NEG_INF)
            return NEG_INF;
        return sat33(s);
    endfunction

    function automatic logic [15:0] lse_term(input logic [4:0] idx);
        logic [31:0] q;
        q = 32'(LSE_LUT[idx]);
        return 16'(((q << FRAC_BITS) + 32'd32768) >> 16);
    endfunction

    function automatic val_t lse(input val_t x, input val_t y);
        val_t hi;
        val_t lo;
        logic [VAL_W:0] d;
        logic [VAL_W:0] k;
        logic [15:0] term;
        logic signed [VAL_W:0] s;
        hi = (x > y) ? x : y;
        lo = (x > y) ? y : x;
        d = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
        k = d >> (FRAC_BITS - 2);
        term = (k < LUT_SIZE) ? lse_term(k[4:0]) : 16'd0;
        s = {hi[VAL_W-1], hi} + $signed({17'd0, term});
        if (x == NEG_INF)
            return y;
        if (y == NEG_INF)
            return x;
        return sat33(s);
    endfunction

endpackage

@@ sv/hfb_if.sv @@
interface hfb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        observed_allele;
    logic [63:0] ref_alleles;
    logic        last_site;
    logic [9:0]  site_index;
    logic [5:0]  ref_index;

    modport source (output valid, req_type, observed_allele, ref_alleles, last_site,
                    site_index, ref_index, input ready);
    modport sink (input valid, req_type, observed_allele, ref_alleles, last_site,
                  site_index, ref_index, output ready);
endinterface

interface hfb_resp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] posterior_log;
    logic [1:0]         status;

    modport source (output valid, posterior_log, status, input ready);
    modport sink (input valid, posterior_log, status, output ready);
endinterface

@@ sv/hmm_forward_backward_posterior_core.sv @@
// copying hmm forward-backward posterior engine, log domain fixed point (q.10)
// req channel (valid/ready): req_type 0 loads one site (observed allele plus
//   one allele bit per reference); last_site on a load starts the passes
//   over all stored sites. req_type 1 reads one posterior at
//   site_index/ref_index and yields one transfer on the resp channel.
// resp channel (valid/ready): posterior_log and status
//   (0 ok, 1 not computed yet, 2 index out of range).
// cfg port: cfg_we/cfg_index/cfg_data, to be written only while the block is idle; the block does not enforce this.
// timing: a load is taken in the idle state; a read goes through the response
//   state into the output register before it shows on resp. a last load keeps
//   the block busy through the forward pass and the backward pass, each site
//   normalized as its column completes, for n = references in use; each lse
//   step reads, adds and accumulates in turn behind the registered memory reads.
// reset: site count and results-ready clear, registers take their defaults;
//   the memories are not cleared and are only read where written.
// a stalled resp holds its result; the next load is still taken, the next
//   read waits until the output register frees.
module hmm_forward_backward_posterior_core (
    input  logic        clk,
    input  logic        rst_n,
    hfb_req_if.sink     req,
    hfb_resp_if.source  resp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import hfb_pkg::*;

    cmd_t       cmd;
    logic [6:0] n_eff;

    // sequencer: loop counters, site count, handshakes
    hfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_type   (req.req_type),
        .in_last   (req.last_site),
        .in_ready  (req.ready),
        .out_valid (resp.valid),
        .out_ready (resp.ready),
        .n_eff     (n_eff),
        .cmd       (cmd)
    );

    // memories, lse unit, config registers, output register
    hfb_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .observed_allele (req.observed_allele),
        .ref_alleles     (req.ref_alleles),
        .site_index      (req.site_index),
        .ref_index       (req.ref_index),
        .n_eff           (n_eff),
        .posterior_log   (resp.posterior_log),
        .status          (resp.status)
    );
endmodule

@@ sv/hfb_ram.sv @@
module hfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/hfb_datapath.sv @@
module hfb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hfb_pkg::cmd_t               cmd,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [16:0]                 cfg_data,
    input  logic                        observed_allele,
    input  logic [63:0]                 ref_alleles,
    input  logic [9:0]                  site_index,
    input  logic [5:0]                  ref_index,
    output logic [6:0]                  n_eff,
    output logic signed [31:0]          posterior_log,
    output logic [1:0]                  status
);
    import hfb_pkg::*;

    logic [NREF_W-1:0] num_refs_reg;
    logic [CFG_W-1:0]  match_reg, mismatch_reg, stay_reg, switch_reg;
    logic [ROW_W-1:0]  row_reg;
    val_t              acc_reg, acc_next;
    val_t              term_reg, term_next;
    logic [1:0]        req_status_reg, req_status_next;
    val_t              post_reg;
    logic [1:0]        status_reg;

    logic [ROW_W-1:0]  site_rdata;
    logic [VAL_W-1:0]  fwd_rdata_raw, bwd_rdata_raw;
    val_t              fwd_rdata, bwd_rdata;
    val_t              fwd_wdata, bwd_wdata;
    logic [FWD_AW-1:0] fwd_raddr;
    val_t              emit_val, tr_val;

    hfb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SITES)) u_site_ram (
        .clk   (clk),
        .we    (cmd.site_we),
        .waddr (cmd.site_waddr),
        .wdata ({observed_allele, ref_alleles}),
        .raddr (cmd.site_raddr),
        .rdata (site_rdata)
    );

    hfb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SITES * MAX_REFS)) u_fwd_ram (
        .clk   (clk),
        .we    (cmd.fwd_we),
        .waddr (cmd.fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata_raw)
    );

    hfb_ram #(.WIDTH(VAL_W), .DEPTH(2 * MAX_REFS)) u_bwd_ram (
        .clk   (clk),
        .we    (cmd.bwd_we),
        .waddr (cmd.bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (cmd.bwd_raddr),
        .rdata (bwd_rdata_raw)
    );

    assign fwd_rdata = $signed(fwd_rdata_raw);
    assign bwd_rdata = $signed(bwd_rdata_raw);
    assign fwd_raddr = cmd.fwd_raddr_req ? {site_index, ref_index} : cmd.fwd_raddr;

    // effective reference count
    always_comb
    begin
        if (num_refs_reg == '0)
            n_eff = NREF_W'(1);
        else if (num_refs_reg > NREF_W'(MAX_REFS))
            n_eff = NREF_W'(MAX_REFS);
        else
            n_eff = num_refs_reg;
    end

    assign emit_val = (row_reg[cmd.emit_idx] == row_reg[MAX_REFS])
                      ? {{(VAL_W-CFG_W){match_reg[CFG_W-1]}}, match_reg}
                      : {{(VAL_W-CFG_W){mismatch_reg[CFG_W-1]}}, mismatch_reg};
    assign tr_val = cmd.tr_same ? {{(VAL_W-CFG_W){stay_reg[CFG_W-1]}}, stay_reg}
                                : {{(VAL_W-CFG_W){switch_reg[CFG_W-1]}}, switch_reg};

    always_comb
    begin
        case (cmd.fwd_wsel)
            FW_EMIT:     fwd_wdata = emit_val;
            FW_ACC_EMIT: fwd_wdata = sat_add(acc_reg, emit_val);
            FW_NORM:     fwd_wdata = sat_sub(term_reg, acc_reg);
            default:     fwd_wdata = emit_val;
        endcase
        bwd_wdata = (cmd.bwd_wsel == BW_ACC) ? acc_reg : '0;
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_CLR: acc_next = NEG_INF;
            ACC_LSE: acc_next = lse(acc_reg, term_reg);
            default: acc_next = acc_reg;
        endcase
        case (cmd.term_op)
            TERM_FWD_TR:      term_next = sat_add(fwd_rdata, tr_val);
            TERM_FWD_BWD:     term_next = sat_add(fwd_rdata, bwd_rdata);
            TERM_BWD_TR_EMIT: term_next = sat_add(sat_add(tr_val, bwd_rdata), emit_val);
            default:          term_next = term_reg;
        endcase
    end

    always_comb
    begin
        if (!cmd.results_ready)
            req_status_next = ST_NOT_READY;
        else if ({1'b0, site_index} >= cmd.site_count || {1'b0, ref_index} >= n_eff)
            req_status_next = ST_RANGE;
        else
            req_status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_refs_reg <= NREF_W'(MAX_REFS);
            match_reg    <= 17'sd0;
            mismatch_reg <= -17'sd10240;
            stay_reg     <= -17'sd470;
            switch_reg   <= -17'sd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_REFS:      num_refs_reg <= cfg_data[NREF_W-1:0];
                CFG_MATCH_EMIT:    match_reg    <= cfg_data;
                CFG_MISMATCH_EMIT: mismatch_reg <= cfg_data;
                CFG_STAY:          stay_reg     <= cfg_data;
                CFG_SWITCH:        switch_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        term_reg <= term_next;
        if (cmd.latch_site)
            row_reg <= site_rdata;
        if (cmd.req_capture)
            req_status_reg <= req_status_next;
        if (cmd.out_load)
        begin
            post_reg   <= (req_status_reg == ST_OK) ? fwd_rdata : '0;
            status_reg <= req_status_reg;
        end
    end

    assign posterior_log = post_reg;
    assign status        = status_reg;
endmodule

@@ sv/hfb_ctrl.sv @@
module hfb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_type,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  logic [6:0]    n_eff,
    output hfb_pkg::cmd_t cmd
);
    import hfb_pkg::*;

    state_t             state_reg, state_next;
    logic [SITE_W-1:0]  t_reg, t_next;
    logic [NREF_W-1:0]  o_reg, o_next;
    logic [NREF_W-1:0]  k_reg, k_next;
    logic [NREF_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rdy_reg, rdy_next;
    logic               col_reg, col_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_xfer, o_last, k_last, stored;
    logic [CNT_W-1:0]   base_cnt;

    assign in_ready = (state_reg == S_IDLE) && (!in_type || !out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;
    assign o_last   = (o_reg + NREF_W'(1)) == n_reg;
    assign k_last   = (k_reg + NREF_W'(1)) == n_reg;
    assign base_cnt = rdy_reg ? '0 : cnt_reg;
    assign stored   = base_cnt < CNT_W'(MAX_SITES);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_type)
                    state_next = S_RESP;
                else if (in_xfer && in_last)
                    state_next = S_F0_RD;
            end
            S_RESP:    state_next = S_IDLE;
            S_F0_RD:   state_next = S_F0_LAT;
            S_F0_LAT:  state_next = S_F0_WR;
            S_F0_WR:
            begin
                if (o_last)
                    state_next = (cnt_reg > CNT_W'(1)) ? S_FS_RD : S_B_INIT;
            end
            S_FS_RD:   state_next = S_FS_LAT;
            S_FS_LAT:  state_next = S_FI_INIT;
            S_FI_INIT: state_next = S_FI_RD;
            S_FI_RD:   state_next = S_FI_ADD;
            S_FI_ADD:  state_next = S_FI_LSE;
            S_FI_LSE:  state_next = k_last ? S_FI_WR : S_FI_RD;
            S_FI_WR:
            begin
                if (!o_last)
                    state_next = S_FI_INIT;
                else if (({1'b0, t_reg} + CNT_W'(1)) == cnt_reg)
                    state_next = S_B_INIT;
                else
                    state_next = S_FS_RD;
            end
            S_B_INIT:  state_next = o_last ? S_N_INIT : S_B_INIT;
            S_N_INIT:  state_next = S_N1_RD;
            S_N1_RD:   state_next = S_N1_ADD;
            S_N1_ADD:  state_next = S_N1_LSE;
            S_N1_LSE:  state_next = o_last ? S_N2_RD : S_N1_RD;
            S_N2_RD:   state_next = S_N2_ADD;
            S_N2_ADD:  state_next = S_N2_WR;
            S_N2_WR:
            begin
                if (!o_last)
                    state_next = S_N2_RD;
                else
                    state_next = (t_reg == '0) ? S_IDLE : S_BS_RD;
            end
            S_BS_RD:   state_next = S_BS_LAT;
            S_BS_LAT:  state_next = S_BI_INIT;
            S_BI_INIT: state_next = S_BI_RD;
            S_BI_RD:   state_next = S_BI_ADD;
            S_BI_ADD:  state_next = S_BI_LSE;
            S_BI_LSE:  state_next = k_last ? S_BI_WR : S_BI_RD;
            S_BI_WR:   state_next = o_last ? S_N_INIT : S_BI_INIT;
            default:   state_next = S_IDLE;
        endcase
    end

    // counters and flags
    always_comb
    begin
        t_next         = t_reg;
        o_next         = o_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        rdy_next       = rdy_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && !in_type)
                begin
                    rdy_next = 1'b0;
                    cnt_next = stored ? base_cnt + CNT_W'(1) : base_cnt;
                    t_next   = '0;
                    o_next   = '0;
                    n_next   = n_eff;
                    col_next = 1'b0;
                end
            end
            S_RESP:    out_valid_next = 1'b1;
            S_F0_LAT, S_FS_LAT, S_N_INIT, S_BS_LAT: o_next = '0;
            S_F0_WR:
            begin
                o_next = o_last ? '0 : o_reg + NREF_W'(1);
                if (o_last && cnt_reg > CNT_W'(1))
                    t_next = SITE_W'(1);
            end
            S_FI_INIT, S_BI_INIT: k_next = '0;
            S_FI_LSE, S_BI_LSE:   k_next = k_reg + NREF_W'(1);
            S_FI_WR:
            begin
                o_next = o_last ? '0 : o_reg + NREF_W'(1);
                if (o_last && (({1'b0, t_reg} + CNT_W'(1)) != cnt_reg))
                    t_next = t_reg + SITE_W'(1);
            end
            S_B_INIT, S_N1_LSE:   o_next = o_last ? '0 : o_reg + NREF_W'(1);
            S_N2_WR:
            begin
                o_next = o_last ? '0 : o_reg + NREF_W'(1);
                if (o_last && t_reg == '0)
                    rdy_next = 1'b1;
            end
            S_BI_WR:
            begin
                o_next = o_last ? '0 : o_reg + NREF_W'(1);
                if (o_last)
                begin
                    col_next = !col_reg;
                    t_next   = t_reg - SITE_W'(1);
                end
            end
            default: ;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd               = '0;
        cmd.site_waddr    = base_cnt[SITE_W-1:0];
        cmd.site_raddr    = t_reg;
        cmd.fwd_waddr     = {t_reg, o_reg[REF_W-1:0]};
        cmd.fwd_raddr     = {t_reg, o_reg[REF_W-1:0]};
        cmd.fwd_wsel      = FW_EMIT;
        cmd.bwd_wsel      = BW_ZERO;
        cmd.bwd_waddr     = {col_reg, o_reg[REF_W-1:0]};
        cmd.bwd_raddr     = {col_reg, o_reg[REF_W-1:0]};
        cmd.acc_op        = ACC_HOLD;
        cmd.term_op       = TERM_HOLD;
        cmd.emit_idx      = o_reg[REF_W-1:0];
        cmd.tr_same       = (o_reg == k_reg);
        cmd.results_ready = rdy_reg;
        cmd.site_count    = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.site_we       = in_xfer && !in_type && stored;
                cmd.fwd_raddr_req = 1'b1;
                cmd.req_capture   = in_xfer && in_type;
            end
            S_RESP:    cmd.out_load = 1'b1;
            S_F0_LAT, S_FS_LAT, S_BS_LAT: cmd.latch_site = 1'b1;
            S_F0_WR:   cmd.fwd_we = 1'b1;
            S_FI_INIT, S_N_INIT, S_BI_INIT: cmd.acc_op = ACC_CLR;
            S_FI_RD:   cmd.fwd_raddr = {t_reg - SITE_W'(1), k_reg[REF_W-1:0]};
            S_FI_ADD:  cmd.term_op = TERM_FWD_TR;
            S_FI_LSE, S_N1_LSE, S_BI_LSE: cmd.acc_op = ACC_LSE;
            S_FI_WR:
            begin
                cmd.fwd_we   = 1'b1;
                cmd.fwd_wsel = FW_ACC_EMIT;
            end
            S_B_INIT:  cmd.bwd_we = 1'b1;
            S_N1_ADD, S_N2_ADD: cmd.term_op = TERM_FWD_BWD;
            S_N2_WR:
            begin
                cmd.fwd_we   = 1'b1;
                cmd.fwd_wsel = FW_NORM;
            end
            S_BI_RD:   cmd.bwd_raddr = {col_reg, k_reg[REF_W-1:0]};
            S_BI_ADD:
            begin
                cmd.term_op  = TERM_BWD_TR_EMIT;
                cmd.emit_idx = k_reg[REF_W-1:0];
            end
            S_BI_WR:
            begin
                cmd.bwd_we    = 1'b1;
                cmd.bwd_wsel  = BW_ACC;
                cmd.bwd_waddr = {!col_reg, o_reg[REF_W-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            o_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            rdy_reg       <= 1'b0;
            col_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            o_reg         <= o_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            rdy_reg       <= rdy_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_type) |=> (state_reg == S_RESP))
        else $error("read transfer not followed by response load");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy_reg && state_reg != S_IDLE) |-> (state_reg == S_RESP))
        else $error("results flagged ready while passes run");

    a_inner_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FI_RD || state_reg == S_BI_RD) |-> (k_reg < n_reg))
        else $error("inner index beyond reference count");

    a_fwd_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.fwd_we && cmd.fwd_raddr_req))
        else $error("posterior write during request read");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import hfb_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset, channels
    // ------------------------------------------------------------------
    localparam int WATCHDOG_LIMIT = 200000;   // idle cycles with no transfer
    localparam int SETTLE_CYCLES  = 20;       // quiet cycles after the last result

    localparam int NEG_CODE = int'(32'h8000_0000);
    localparam int TOP_CODE = int'(32'h7fff_ffff);

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    hfb_req_if  req_ch ();
    hfb_resp_if resp_ch ();

    hmm_forward_backward_posterior_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .resp      (resp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // stimulus rows: loads, reads and register writes
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {ROW_LOAD, ROW_READ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        obs;
        logic [63:0] alleles;
        logic        last;
        logic [9:0]  site;
        logic [5:0]  refi;
        logic [2:0]  reg_idx;
        int          reg_val;
        logic        typed;       // expected result written in the row
        int          typed_post;
        logic [1:0]  typed_status;
    } row_t;

    typedef struct {
        int         post;
        logic [1:0] status;
    } posterior_t;

    posterior_t posterior_q[$];   // reads in flight, oldest first
    int         error_count;
    int         idle_cycles;

    // ------------------------------------------------------------------
    // posterior predictor: own copy of stores and registers
    // ------------------------------------------------------------------
    logic [6:0]  m_nrefs;
    int          m_match, m_mismatch, m_stay, m_switch;
    logic [63:0] m_alleles [MAX_SITES];
    logic        m_obs [MAX_SITES];
    int          m_post [MAX_SITES][MAX_REFS];
    int          m_count;
    logic        m_ready;

    // ln(1+exp(-k/4)) in q16
    int softplus_q16 [32] = '{
        45426, 37745, 31069, 25354, 20530, 16510, 13200, 10500,
        8318,  6567,  5170,  4061,  3184,  2493,  1950,  1523,
        1189,  928,   724,   565,   440,   343,   267,   208,
        162,   126,   98,    77,    60,    47,    36,    28
    };

    function automatic int clamp32(input longint v);
        if (v <= longint'(NEG_CODE))
            return NEG_CODE;
        if (v > longint'(TOP_CODE))
            return TOP_CODE;
        return int'(v);
    endfunction

    function automatic int add_log(input int a, input int b);
        if (a == NEG_CODE || b == NEG_CODE)
            return NEG_CODE;
        return clamp32(longint'(a) + longint'(b));
    endfunction

    function automatic int log_sum(input int x, input int y);
        int     hi;
        int     lo;
        longint d;
        longint k;
        longint corr;
        if (x == NEG_CODE)
            return y;
        if (y == NEG_CODE)
            return x;
        hi = (x > y) ? x : y;
        lo = (x > y) ? y : x;
        d = longint'(hi) - longint'(lo);
        k = (d << 2) >>> FRAC_BITS;
        corr = 0;
        if (k < 32)
            corr = ((longint'(softplus_q16[k]) << FRAC_BITS) + 32768) >>> 16;
        return clamp32(longint'(hi) + corr);
    endfunction

    function automatic int refs_in_use();
        if (m_nrefs == 0)
            return 1;
        if (m_nrefs > MAX_REFS)
            return MAX_REFS;
        return int'(m_nrefs);
    endfunction

    function automatic int emission(input int j, input int t);
        return (m_alleles[t][j] == m_obs[t]) ? m_match : m_mismatch;
    endfunction

    function automatic int transition(input int i, input int j);
        return (i == j) ? m_stay : m_switch;
    endfunction

    task automatic normalize_site(input int t, input int n, input int beta [MAX_REFS]);
        int p [MAX_REFS];
        int norm;
        norm = NEG_CODE;
        for (int i = 0; i < n; i++)
        begin
            p[i] = add_log(m_post[t][i], beta[i]);
            norm = log_sum(norm, p[i]);
        end
        for (int i = 0; i < n; i++)
        begin
            if (p[i] == NEG_CODE || norm == NEG_CODE)
                m_post[t][i] = NEG_CODE;
            else
                m_post[t][i] = clamp32(longint'(p[i]) - longint'(norm));
        end
    endtask

    task automatic forward_backward();
        int n;
        int acc;
        int beta_cur [MAX_REFS];
        int beta_nxt [MAX_REFS];
        n = refs_in_use();
        // forward pass, kept in the posterior store
        for (int j = 0; j < n; j++)
            m_post[0][j] = emission(j, 0);
        for (int t = 1; t < m_count; t++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = NEG_CODE;
                for (int i = 0; i < n; i++)
                    acc = log_sum(acc, add_log(m_post[t-1][i], transition(i, j)));
                m_post[t][j] = add_log(acc, emission(j, t));
            end
        end
        // backward pass, normalizing each site as its column completes
        for (int i = 0; i < MAX_REFS; i++)
            beta_nxt[i] = 0;
        normalize_site(m_count - 1, n, beta_nxt);
        for (int t = m_count - 1; t > 0; t--)
        begin
            for (int i = 0; i < n; i++)
            begin
                acc = NEG_CODE;
                for (int j = 0; j < n; j++)
                    acc = log_sum(acc, add_log(add_log(transition(i, j), beta_nxt[j]),
                                               emission(j, t)));
                beta_cur[i] = acc;
            end
            normalize_site(t - 1, n, beta_cur);
            beta_nxt = beta_cur;
        end
        m_ready = 1'b1;
    endtask

    // predict one accepted request; a read yields one posterior
    task automatic predict_transfer(input row_t r, output logic has_res, output posterior_t res);
        has_res = 1'b0;
        res.post = 0;
        res.status = ST_OK;
        if (r.kind == ROW_LOAD)
        begin
            if (m_ready)
            begin
                m_ready = 1'b0;
                m_count = 0;
            end
            if (m_count < MAX_SITES)
            begin
                m_alleles[m_count] = r.alleles;
                m_obs[m_count] = r.obs;
                m_count++;
            end
            if (r.last && m_count > 0)
                forward_backward();
        end
        else
        begin
            has_res = 1'b1;
            if (!m_ready)
                res.status = ST_NOT_READY;
            else if (int'(r.site) >= m_count || int'(r.refi) >= refs_in_use())
                res.status = ST_RANGE;
            else
                res.post = m_post[r.site][r.refi];
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts with random gaps between them
    // ------------------------------------------------------------------
    int burst_left;

    task automatic drive_request(input row_t r);
        logic       has_res;
        posterior_t res;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            // some bursts are long stretches with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= (r.kind == ROW_READ);
        req_ch.observed_allele <= r.obs;
        req_ch.ref_alleles     <= r.alleles;
        req_ch.last_site       <= r.last;
        req_ch.site_index      <= r.site;
        req_ch.ref_index       <= r.refi;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // transfer at this edge
        predict_transfer(r, has_res, res);
        if (has_res)
        begin
            if (r.typed)
            begin
                res.post = r.typed_post;
                res.status = r.typed_status;
            end
            posterior_q.insert(posterior_q.size(), res);
        end
        burst_left--;
        @(negedge clk);
    endtask

    // wait for every outstanding read, then leave the block a few quiet cycles
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (posterior_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input int val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[16:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_NUM_REFS:      m_nrefs = val[6:0];
            CFG_MATCH_EMIT:    m_match = int'($signed(val[16:0]));
            CFG_MISMATCH_EMIT: m_mismatch = int'($signed(val[16:0]));
            CFG_STAY:          m_stay = int'($signed(val[16:0]));
            CFG_SWITCH:        m_switch = int'($signed(val[16:0]));
            default: ;
        endcase
    endtask

    task automatic run_row(input row_t r);
        if (r.kind == ROW_CFG)
            write_reg(r.reg_idx, r.reg_val);
        else
            drive_request(r);
    endtask

    function automatic row_t load_row(input logic obs, input logic [63:0] alleles,
                                      input logic last);
        row_t r;
        r = '{kind: ROW_LOAD, obs: obs, alleles: alleles, last: last, site: 0, refi: 0,
              reg_idx: 0, reg_val: 0, typed: 0, typed_post: 0, typed_status: ST_OK};
        return r;
    endfunction

    function automatic row_t read_row(input int site, input int refi, input logic typed,
                                      input logic [1:0] status);
        row_t r;
        r = '{kind: ROW_READ, obs: 0, alleles: 0, last: 0, site: site[9:0],
              refi: refi[5:0], reg_idx: 0, reg_val: 0, typed: typed, typed_post: 0,
              typed_status: status};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [2:0] idx, input int val);
        row_t r;
        r = '{kind: ROW_CFG, obs: 0, alleles: 0, last: 0, site: 0, refi: 0,
              reg_idx: idx, reg_val: val, typed: 0, typed_post: 0, typed_status: ST_OK};
        return r;
    endfunction

    function automatic int rand_log_value();
        case ($urandom_range(0, 5))
            0: return -65536;
            1: return 0;
            2: return -int'($urandom_range(0, 65536));
            default: return -int'($urandom_range(0, 12000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result receiver: ready follows a stall pattern of its own
    // ------------------------------------------------------------------
    int stall_mode;
    int stall_left;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       resp_ch.ready <= 1'b1;
            1:       resp_ch.ready <= $urandom_range(0, 1);
            default: resp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // checker on the result channel
    always @(posedge clk)
    begin
        posterior_t want;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            if (posterior_q.size() == 0)
                report_mismatch("unexpected result, status", resp_ch.status, -1);
            else
            begin
                want = posterior_q.pop_front();
                if (resp_ch.status !== want.status)
                    report_mismatch("status", resp_ch.status, want.status);
                if (resp_ch.posterior_log !== want.post)
                    report_mismatch("posterior_log", resp_ch.posterior_log, want.post);
            end
        end
    end

    // watchdog: cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("hmm_forward_backward_posterior_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    row_t directed [$];

    task automatic queue_row(input row_t r);
        directed.insert(directed.size(), r);
    endtask

    initial
    begin
        int          rand_items;
        int          sites;
        int          n_reads;
        int          n;
        logic [63:0] alleles;

        error_count = 0;
        idle_cycles = 0;
        burst_left  = 0;
        stall_left  = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_NUM_REFS;
        cfg_data    = '0;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = 1'b0;
        req_ch.observed_allele = 1'b0;
        req_ch.ref_alleles     = '0;
        req_ch.last_site       = 1'b0;
        req_ch.site_index      = '0;
        req_ch.ref_index       = '0;
        resp_ch.ready          = 1'b0;

        // register defaults after reset
        m_nrefs = 7'd64;
        m_match = 0;
        m_mismatch = -10240;
        m_stay = -470;
        m_switch = -1024;
        m_count = 0;
        m_ready = 1'b0;

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: read before any passes, full reference set, range errors
        queue_row(read_row(0, 0, 1, ST_NOT_READY));
        queue_row(load_row(1, '1, 0));
        queue_row(load_row(0, '0, 0));
        queue_row(load_row(1, 64'hAAAA_AAAA_AAAA_AAAA, 1));
        queue_row(read_row(0, 0, 0, ST_OK));
        queue_row(read_row(2, 63, 0, ST_OK));
        queue_row(read_row(1, 31, 0, ST_OK));
        queue_row(read_row(3, 0, 1, ST_RANGE));
        queue_row(read_row(1023, 63, 1, ST_RANGE));
        // fewer references after the passes: reads use the new count
        queue_row(cfg_row(CFG_NUM_REFS, 2));
        queue_row(read_row(0, 2, 1, ST_RANGE));
        queue_row(read_row(0, 1, 0, ST_OK));
        // zero references acts as one, extreme log values
        queue_row(cfg_row(CFG_NUM_REFS, 0));
        queue_row(cfg_row(CFG_MATCH_EMIT, -65536));
        queue_row(cfg_row(CFG_MISMATCH_EMIT, 0));
        queue_row(cfg_row(CFG_STAY, -65536));
        queue_row(cfg_row(CFG_SWITCH, 0));
        // load after results clears them
        queue_row(load_row(0, 64'h5555_5555_5555_5555, 0));
        queue_row(read_row(0, 0, 1, ST_NOT_READY));
        queue_row(load_row(1, 64'h1, 1));
        queue_row(read_row(1, 0, 0, ST_OK));
        queue_row(read_row(0, 1, 1, ST_RANGE));
        // reference count above the maximum acts as the maximum
        queue_row(cfg_row(CFG_NUM_REFS, 100));
        queue_row(cfg_row(CFG_MATCH_EMIT, 0));
        queue_row(cfg_row(CFG_MISMATCH_EMIT, -65536));
        queue_row(cfg_row(CFG_STAY, 0));
        queue_row(cfg_row(CFG_SWITCH, -65536));
        queue_row(load_row(0, 64'hFFFF_0000_F0F0_0F0F, 1));
        queue_row(read_row(0, 63, 0, ST_OK));
        queue_row(read_row(0, 0, 0, ST_OK));

        foreach (directed[i])
            run_row(directed[i]);

        // store full: one load beyond the store, marked last
        write_reg(CFG_NUM_REFS, 1);
        for (int s = 0; s <= MAX_SITES; s++)
            drive_request(load_row($urandom_range(0, 1), {$urandom, $urandom},
                                   s == MAX_SITES));
        drive_request(read_row(1023, 0, 0, ST_OK));
        drive_request(read_row(0, 0, 0, ST_OK));

        // random sequences: new settings, a few sites, then reads
        rand_items = 0;
        while (rand_items < 100)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
            if (n > 8 && n < 64)
                n = 8;
            write_reg(CFG_NUM_REFS, n);
            write_reg(CFG_MATCH_EMIT, rand_log_value());
            write_reg(CFG_MISMATCH_EMIT, rand_log_value());
            write_reg(CFG_STAY, rand_log_value());
            write_reg(CFG_SWITCH, rand_log_value());
            // wide reference counts only with a single site to keep passes short
            sites = (n > 8 || n == 0) ? 1 : $urandom_range(1, 4);
            for (int s = 0; s < sites; s++)
            begin
                alleles = {$urandom, $urandom};
                drive_request(load_row($urandom_range(0, 1), alleles, s == sites - 1));
                rand_items++;
                // noise: read while the sequence is still open
                if (s < sites - 1 && $urandom_range(0, 4) == 0)
                begin
                    drive_request(read_row($urandom_range(0, 1023), $urandom_range(0, 63),
                                           0, ST_OK));
                    rand_items++;
                end
            end
            n_reads = $urandom_range(2, 6);
            for (int k = 0; k < n_reads; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                    drive_request(read_row($urandom_range(0, 1023), $urandom_range(0, 63),
                                           0, ST_OK));
                else
                    drive_request(read_row($urandom_range(0, sites - 1),
                                           $urandom_range(0, refs_in_use() - 1), 0, ST_OK));
                rand_items++;
            end
        end

        // wind down
        req_ch.valid <= 1'b0;
        while (posterior_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (error_count == 0)
            $display("hmm_forward_backward_posterior_core: match");
        else
            $display("hmm_forward_backward_posterior_core: mismatch");
        $finish;
    end

endmodule

@@ hmm_forward_backward_posterior_core.f @@
sv/hfb_pkg.sv
sv/hfb_if.sv
sv/hfb_ram.sv
sv/hfb_datapath.sv
sv/hfb_ctrl.sv
sv/hmm_forward_backward_posterior_core.sv
tb/tb.sv
